// File: rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the summed-area table stream.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int LUMA_W = 16;
    localparam int SAT_W  = 36;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic [LUMA_W-1:0] luma_sample;
        logic              start_of_frame;
    } sat_in_t;

    typedef struct packed {
        logic [SAT_W-1:0] sat_value;
        logic             end_of_frame;
    } sat_out_t;

    typedef struct packed {
        logic row_zero;
        logic end_of_frame;
    } sat_flags_t;

endpackage

// File: rtl/sat_line_store.sv
// ----------------------------------------------------------------------------
// sat_line_store
// Previous-row line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sat_line_store
    import sat_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SAT_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SAT_W-1:0]  wr_data
);

    logic [SAT_W-1:0] mem [DEPTH];
    logic [SAT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sat_pos.sv
// ----------------------------------------------------------------------------
// sat_pos
// Size registers, raster position counters and the row running sum.
// ----------------------------------------------------------------------------
module sat_pos
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 10,
    parameter int SMP_W      = 16,
    parameter int RUN_W      = 26
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_fire,
    input  sat_in_t          in_data,
    output logic [COL_W-1:0] col,
    output logic [RUN_W-1:0] run,
    output sat_flags_t       flags
);

    localparam int WD_W = CFG_W + COL_W + 1;
    localparam int HD_W = CFG_W + ROW_W + 1;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [WD_W-1:0] w_ext, w_eff, w_last;
    logic [HD_W-1:0] h_ext, h_eff, h_last;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [RUN_W-1:0] cur_run;
    logic             last_col, last_row;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_ext = {{(WD_W-CFG_W){1'b0}}, width_reg};
        h_ext = {{(HD_W-CFG_W){1'b0}}, height_reg};
        if (w_ext == '0)
            w_eff = WD_W'(1);
        else if (w_ext > WD_W'(MAX_WIDTH))
            w_eff = WD_W'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = HD_W'(1);
        else if (h_ext > HD_W'(MAX_HEIGHT))
            h_eff = HD_W'(MAX_HEIGHT);
        else
            h_eff = h_ext;
        w_last = w_eff - WD_W'(1);
        h_last = h_eff - HD_W'(1);
    end

    always_comb
    begin
        cur_col  = in_data.start_of_frame ? '0 : col_reg;
        cur_row  = in_data.start_of_frame ? '0 : row_reg;
        cur_run  = (in_data.start_of_frame ? '0 : run_reg)
                 + {{(RUN_W-SMP_W){1'b0}}, in_data.luma_sample[SMP_W-1:0]};
        last_col = {{(WD_W-COL_W){1'b0}}, cur_col} >= w_last;
        last_row = {{(HD_W-ROW_W){1'b0}}, cur_row} >= h_last;

        col_next = col_reg;
        row_next = row_reg;
        run_next = run_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                run_next = '0;
                row_next = last_row ? '0 : cur_row + ROW_W'(1);
            end
            else
            begin
                col_next = cur_col + COL_W'(1);
                row_next = cur_row;
                run_next = cur_run;
            end
        end
    end

    assign col                = cur_col;
    assign run                = cur_run;
    assign flags.row_zero     = (cur_row == '0);
    assign flags.end_of_frame = last_col && last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_SIZE_RESET;
            height_reg <= CFG_SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            run_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            run_reg    <= run_next;
        end
    end

endmodule

// File: rtl/summed_area_table_stream.sv
// Each pixel is registered in the s1 stage, and its result is then registered in
// the output register that drives out_data.
// Throughput: 1 pixel per cycle while the sink does not stall; the line store's single read and write
// ports each see one access per pixel.
// Reset: position, running sum and handshake state clear; size registers
// return to 1024; the line store is not cleared (first row never uses it).
// ----------------------------------------------------------------------------
// summed_area_table_stream
// Streaming integral image: row running sum plus previous-row line store.
// ----------------------------------------------------------------------------
module summed_area_table_stream
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  sat_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output sat_out_t         out_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SMP_W = (SAMPLE_BITS < LUMA_W) ? SAMPLE_BITS : LUMA_W;
    localparam int RUN_W = SMP_W + COL_W;

    logic             in_fire, s1_fire;
    logic [COL_W-1:0] pos_col;
    logic [RUN_W-1:0] pos_run;
    sat_flags_t       pos_flags;
    logic [SAT_W-1:0] rd_data;

    logic             s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0] s1_addr_reg, s1_addr_next;
    logic [RUN_W-1:0] s1_run_reg, s1_run_next;
    sat_flags_t       s1_flags_reg, s1_flags_next;
    logic             fwd_reg, fwd_next;
    logic [SAT_W-1:0] fwd_data_reg, fwd_data_next;
    logic             out_valid_reg, out_valid_next;
    sat_out_t         out_data_reg, out_data_next;

    logic [SAT_W-1:0] above, sat;

    sat_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .SMP_W      (SMP_W),
        .RUN_W      (RUN_W)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_data   (in_data),
        .col       (pos_col),
        .run       (pos_run),
        .flags     (pos_flags)
    );

    sat_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (pos_col),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (sat)
    );

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    // same-column write in flight while the read issues: take the new value
    always_comb
    begin
        if (s1_flags_reg.row_zero)
            above = '0;
        else if (fwd_reg)
            above = fwd_data_reg;
        else
            above = rd_data;
        sat = {{(SAT_W-RUN_W){1'b0}}, s1_run_reg} + above;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_addr_next   = s1_addr_reg;
        s1_run_next    = s1_run_reg;
        s1_flags_next  = s1_flags_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (s1_fire)
        begin
            out_valid_next             = 1'b1;
            out_data_next.sat_value    = sat;
            out_data_next.end_of_frame = s1_flags_reg.end_of_frame;
            s1_valid_next              = 1'b0;
            fwd_next                   = 1'b0;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_addr_next  = pos_col;
            s1_run_next   = pos_run;
            s1_flags_next = pos_flags;
            fwd_next      = s1_fire && (s1_addr_reg == pos_col);
            fwd_data_next = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        s1_run_reg   <= s1_run_next;
        s1_flags_reg <= s1_flags_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty stage");

    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set without pending pixel");

    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("stage transaction lost before output");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/sat_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_stream_checker
// Watches the pixel and result channels and the size register port of the
// summed-area table stream. Every accepted pixel is run through a local
// integral-image predictor (row running sum plus previous-row line store).
// Every accepted result is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module sat_stream_checker
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  sat_in_t          in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  sat_out_t         out_data,
    output int               mismatch_count,
    output int               pending
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int ROW_SUM_W = COL_W + SAMPLE_BITS;

    localparam logic [LUMA_W-1:0] LUMA_MASK = LUMA_W'((64'd1 << SAMPLE_BITS) - 1);

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [ROW_SUM_W-1:0] row_sum;
    logic [SAT_W-1:0]     line_store [MAX_WIDTH];

    sat_out_t sat_expected_q [$];

    initial mismatch_count = 0;

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic sat_out_t integrate_pixel(sat_in_t px);
        int               w;
        int               h;
        logic [SAT_W-1:0] above;
        logic [SAT_W-1:0] total;
        logic             last_col;
        logic             last_row;
        sat_out_t         res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (px.start_of_frame)
        begin
            col     = '0;
            row     = '0;
            row_sum = '0;
        end
        row_sum = row_sum + ROW_SUM_W'(px.luma_sample & LUMA_MASK);
        above   = (row == '0) ? '0 : line_store[col];
        total   = SAT_W'(row_sum) + above;
        line_store[col] = total;
        last_col = int'(col) >= w - 1;
        last_row = int'(row) >= h - 1;
        res.sat_value    = total;
        res.end_of_frame = last_col && last_row;
        if (last_col)
        begin
            col     = '0;
            row_sum = '0;
            row     = last_row ? '0 : row + ROW_W'(1);
        end
        else
        begin
            col = col + COL_W'(1);
        end
        return res;
    endfunction

    task automatic flag_miss(input string what, input sat_out_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected sat=%0d eof=%0b, got sat=%0d eof=%0b", $realtime,
                     what, want.sat_value, want.end_of_frame, out_data.sat_value,
                     out_data.end_of_frame);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sat_out_t want;
        if (!rst_n)
        begin
            width_reg  = CFG_SIZE_RESET;
            height_reg = CFG_SIZE_RESET;
            col        = '0;
            row        = '0;
            row_sum    = '0;
            sat_expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (sat_expected_q.size() == 0)
                begin
                    want = '0;
                    flag_miss("unexpected result transaction", want);
                end
                else
                begin
                    want = sat_expected_q.pop_front();
                    if (out_data.sat_value !== want.sat_value ||
                        out_data.end_of_frame !== want.end_of_frame)
                        flag_miss("result mismatch", want);
                end
            end
            if (in_valid && !in_stall)
                sat_expected_q.push_back(integrate_pixel(in_data));
            pending <= sat_expected_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the summed-area table stream. Fills the first line
// store entries with a partial row, runs a short directed set (extreme samples,
// start marks mid-frame and missing, out-of-range and mid-frame size changes,
// one long sink hold-off), then random frames with random source gaps and sink
// stalls. Prediction and comparison live in sat_stream_checker.
// ----------------------------------------------------------------------------
module tb;
    import sat_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 250;
    localparam int PRELOAD_PX   = 64;
    localparam int RANDOM_MAX_W = 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    sat_in_t          in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    sat_out_t         out_data;

    int mismatch_count;
    int pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;

    summed_area_table_stream #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    sat_stream_checker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("summed_area_table_stream: mismatch");
                $finish;
            end
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    function automatic logic [LUMA_W-1:0] pick_luma();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {LUMA_W{1'b1}};
            default: return LUMA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return {CFG_W{1'b1}};
            2: return CFG_W'(1024);
            3: return CFG_W'($urandom_range(0, 2047));
            4: return CFG_W'($urandom_range(9, 40));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic int eff_dim(logic [CFG_W-1:0] v, int lim);
        return (v == '0) ? 1 : ((int'(v) > lim) ? lim : int'(v));
    endfunction

    task automatic send_pixel(input logic [LUMA_W-1:0] luma, input logic sof);
        int      gap;
        sat_in_t px;
        gap = quiet ? 0 : $urandom_range(0, 11);
        px.luma_sample    = luma;
        px.start_of_frame = sof;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    // wait for the pipeline to drain before touching the size registers
    task automatic write_size(input logic [CFG_W-1:0] width_v,
                              input logic [CFG_W-1:0] height_v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width_v;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height_v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int i;
        int f;
        int p;
        int frames;
        int frame_px;
        int phase_px;
        int sent;
        bit aligned;
        bit sof;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // partial row at reset size writes every entry that later rows can read
        for (i = 0; i < PRELOAD_PX; i++)
            send_pixel(pick_luma(), i == 0);

        // full-scale samples, then a wrap with no start mark, then a restart mid-frame
        write_size(CFG_W'(3), CFG_W'(2));
        for (i = 0; i < 6; i++)
            send_pixel({LUMA_W{1'b1}}, i == 0);
        for (i = 0; i < 5; i++)
            send_pixel(i < 3 ? '0 : 16'h8001, i == 3);

        // zero and oversize register values
        write_size('0, {CFG_W{1'b1}});
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        write_size({CFG_W{1'b1}}, '0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'hFFFE, 1'b0);

        // size shrinks, then grows, in the middle of a frame
        write_size(CFG_W'(4), CFG_W'(4));
        for (i = 0; i < 5; i++)
            send_pixel(pick_luma(), i == 0);
        write_size(CFG_W'(2), CFG_W'(1));
        send_pixel(pick_luma(), 1'b0);
        send_pixel(pick_luma(), 1'b0);
        write_size(CFG_W'(5), CFG_W'(3));
        for (i = 0; i < 3; i++)
            send_pixel(pick_luma(), 1'b0);

        // back-pressure: sink holds off while the source streams
        write_size(CFG_W'(6), CFG_W'(4));
        quiet = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 60; i++)
            send_pixel(pick_luma(), i == 0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = pick_dim();
            if (eff_dim(w, MAX_WIDTH) > RANDOM_MAX_W)
                w = CFG_W'($urandom_range(1, RANDOM_MAX_W));
            h = pick_dim();
            write_size(w, h);
            quiet    = ($urandom_range(0, 3) == 0);
            aligned  = ($urandom_range(0, 4) != 0);
            frames   = $urandom_range(1, 4);
            frame_px = eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT);
            phase_px = 0;
            for (f = 0; f < frames && phase_px < 80; f++)
            begin
                for (p = 0; p < frame_px && phase_px < 80; p++)
                begin
                    sof = (p == 0) && (f == 0 ? aligned : ($urandom_range(0, 3) != 0));
                    if ($urandom_range(0, 63) == 0)
                        sof = 1'b1;
                    send_pixel(pick_luma(), sof);
                    phase_px++;
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("summed_area_table_stream: match");
        else
            $display("summed_area_table_stream: mismatch");
        $finish;
    end

endmodule
